[rtl/core/thermal_guard_limit_governor_core_defines.svh]
// ----------------------------------------------------------------------------
// Thermal guard governor assertion macros
// Shared concurrent assertion forms, clocked by clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef THERMAL_GUARD_LIMIT_GOVERNOR_CORE_DEFINES_SVH
`define THERMAL_GUARD_LIMIT_GOVERNOR_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TGLG_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TGLG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/tglg_pkg.sv]
// ----------------------------------------------------------------------------
// Thermal guard governor package
// Shared types, codes and clamp helpers for the governor core.
// ----------------------------------------------------------------------------
package tglg_pkg;

	typedef enum logic [2:0] {
		CMD_SAMPLE    = 3'd0,
		CMD_POWER_REQ = 3'd1,
		CMD_FREQ_REQ  = 3'd2,
		CMD_ESTOP     = 3'd3,
		CMD_RESET     = 3'd4
	} tglg_cmd_t;

	typedef enum logic [2:0] {
		KIND_NONE      = 3'd0,
		KIND_CRITICAL  = 3'd1,
		KIND_ENGAGED   = 3'd2,
		KIND_RECOVERED = 3'd3,
		KIND_CAPPED    = 3'd4,
		KIND_CLAMPED   = 3'd5
	} tglg_kind_t;

	localparam logic [7:0] REG_CRITICAL_TEMP  = 8'd0;
	localparam logic [7:0] REG_THROTTLE_TEMP  = 8'd1;
	localparam logic [7:0] REG_RECOVER_TEMP   = 8'd2;
	localparam logic [7:0] REG_POWER_FLOOR    = 8'd3;
	localparam logic [7:0] REG_POWER_CEILING  = 8'd4;
	localparam logic [7:0] REG_THROTTLE_POWER = 8'd5;
	localparam logic [7:0] REG_FREQ_FLOOR     = 8'd6;
	localparam logic [7:0] REG_THROTTLE_FREQ  = 8'd7;

	localparam logic [13:0] POWER_LIMIT_RESET = 14'd3000;

	typedef struct packed {
		logic [10:0] critical_temp;
		logic [10:0] throttle_temp;
		logic [10:0] recover_temp;
		logic [13:0] power_floor;
		logic [13:0] power_ceiling;
		logic [13:0] throttle_power;
		logic [11:0] freq_floor;
		logic [11:0] throttle_freq;
	} tglg_cfg_t;

	typedef struct packed {
		logic [13:0] power_limit;
		logic [11:0] freq_limit;
		logic        guard;
		logic [15:0] event_total;
		logic [31:0] last_event_ms;
	} tglg_state_t;

	typedef struct packed {
		tglg_cmd_t          cmd;
		logic signed [11:0] temperature;
		logic [13:0]        power_request;
		logic [11:0]        freq_request;
		logic [31:0]        now_ms;
	} tglg_item_t;

	// Below the floor gives the floor, otherwise above the ceiling gives the ceiling.
	function automatic logic [13:0] clamp_power(input logic [13:0] v, input logic [13:0] lo,
		input logic [13:0] hi);
		logic [13:0] r;
		if (v < lo) r = lo;
		else if (v > hi) r = hi;
		else r = v;
		return r;
	endfunction

	function automatic logic [11:0] clamp_freq(input logic [11:0] v, input logic [11:0] lo,
		input logic [11:0] hi);
		logic [11:0] r;
		if (v < lo) r = lo;
		else if (v > hi) r = hi;
		else r = v;
		return r;
	endfunction

endpackage

[rtl/core/tglg_step.sv]
// ----------------------------------------------------------------------------
// Thermal guard governor step logic
// Next limits, guard, event count and event kind for one command.
// ----------------------------------------------------------------------------
module tglg_step #(
	parameter int unsigned FREQ_CEILING = 2500
) (
	input  tglg_pkg::tglg_cfg_t   cfg,
	input  tglg_pkg::tglg_state_t state,
	input  tglg_pkg::tglg_item_t  item,
	output tglg_pkg::tglg_state_t nxt,
	output tglg_pkg::tglg_kind_t  kind
);

	localparam logic [11:0] FreqCeil = 12'(FREQ_CEILING);

	logic        at_critical;
	logic        at_throttle;
	logic        below_recover;
	logic        count;
	logic [13:0] tpow_clamped;
	logic [13:0] preq_clamped;
	logic [11:0] freq_clamped;
	logic [15:0] total_inc;

	assign at_critical   = $signed(item.temperature) >= $signed({1'b0, cfg.critical_temp});
	assign at_throttle   = $signed(item.temperature) >= $signed({1'b0, cfg.throttle_temp});
	assign below_recover = $signed(item.temperature) < $signed({1'b0, cfg.recover_temp});
	assign tpow_clamped  = tglg_pkg::clamp_power(cfg.throttle_power, cfg.power_floor,
		cfg.power_ceiling);
	assign preq_clamped  = tglg_pkg::clamp_power(item.power_request, cfg.power_floor,
		cfg.power_ceiling);
	assign freq_clamped  = tglg_pkg::clamp_freq(item.freq_request, cfg.freq_floor, FreqCeil);
	// The counter saturates at all ones.
	assign total_inc     = (state.event_total != '1) ? state.event_total + 16'd1
		: state.event_total;

	always_comb begin
		nxt   = state;
		kind  = tglg_pkg::KIND_NONE;
		count = 1'b0;
		unique case (item.cmd)
			tglg_pkg::CMD_SAMPLE: begin
				if (at_critical) begin
					nxt.power_limit = cfg.power_floor;
					nxt.freq_limit  = cfg.freq_floor;
					nxt.guard       = 1'b1;
					count           = 1'b1;
					kind            = tglg_pkg::KIND_CRITICAL;
				end else begin
					if (at_throttle) begin
						if (!state.guard) begin
							nxt.guard = 1'b1;
							count     = 1'b1;
							kind      = tglg_pkg::KIND_ENGAGED;
						end
						nxt.power_limit = tpow_clamped;
					end
					// With recovery set above throttle, a sample may engage and release at once.
					if (nxt.guard && below_recover) begin
						nxt.guard = 1'b0;
						kind      = tglg_pkg::KIND_RECOVERED;
					end
				end
			end
			tglg_pkg::CMD_POWER_REQ: begin
				nxt.power_limit = preq_clamped;
				kind = (preq_clamped != item.power_request) ? tglg_pkg::KIND_CLAMPED
					: tglg_pkg::KIND_NONE;
				if (state.guard && (preq_clamped > cfg.throttle_power)) begin
					nxt.power_limit = cfg.throttle_power;
					kind            = tglg_pkg::KIND_CAPPED;
				end
			end
			tglg_pkg::CMD_FREQ_REQ: begin
				nxt.freq_limit = freq_clamped;
				kind = (freq_clamped != item.freq_request) ? tglg_pkg::KIND_CLAMPED
					: tglg_pkg::KIND_NONE;
				if (state.guard && (freq_clamped > cfg.throttle_freq)) begin
					nxt.freq_limit = cfg.throttle_freq;
					kind           = tglg_pkg::KIND_CAPPED;
				end
			end
			tglg_pkg::CMD_ESTOP: begin
				nxt.power_limit = cfg.power_floor;
				nxt.freq_limit  = cfg.freq_floor;
				nxt.guard       = 1'b1;
			end
			tglg_pkg::CMD_RESET: begin
				nxt.power_limit = cfg.power_ceiling;
				nxt.freq_limit  = FreqCeil;
				nxt.guard       = 1'b0;
			end
			default: begin
				nxt = state;
			end
		endcase
		if (count) begin
			nxt.event_total   = total_inc;
			nxt.last_event_ms = item.now_ms;
		end
	end

endmodule

[rtl/core/thermal_guard_limit_governor_core.sv]
// ----------------------------------------------------------------------------
// Thermal guard limit governor core
// Throttling governor with hysteresis over power and frequency limits.
// ----------------------------------------------------------------------------
// Usage: commands arrive on the s_* stream (command in s_tuser) and every
// command produces exactly one result item on the m_* stream, carrying the
// limits, guard flag, event count and last event time after that command,
// with the event kind in m_tuser.
// Each accepted item passes through the input register, then the step
// logic loads the result register and the governor state in the same
// edge. Throughput is one item per cycle while the receiver keeps up;
// the state feedback is a single compare-and-select pass between the
// input register and the state.
// When the receiver stalls, the result register holds and the input
// register still takes one more item; s_tready then drops until the
// result is taken. Configuration writes on the cfg_* channel are always
// ready and take effect at once; they are meant for idle periods.
// Reset loads the default thresholds, the power ceiling and frequency
// ceiling as limits, and clears the guard, counter and event time.
module thermal_guard_limit_governor_core #(
	parameter int unsigned FREQ_CEILING = 2500
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [11:0] temperature, [25:12] power_request, [37:26] freq_request,
	// [69:38] now_ms, [71:70] zero
	input  logic [71:0] s_tdata,
	// [2:0] command
	input  logic [2:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [13:0] power_limit, [25:14] freq_limit, [26] guard_active,
	// [42:27] event_total, [74:43] last_event_ms, [79:75] zero
	output logic [79:0] m_tdata,
	// [2:0] event_kind
	output logic [2:0]  m_tuser,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	`include "thermal_guard_limit_governor_core_defines.svh"

	localparam logic [11:0] FreqCeil = 12'(FREQ_CEILING);

	tglg_pkg::tglg_cfg_t   cfg_q;
	tglg_pkg::tglg_state_t state_q;
	tglg_pkg::tglg_state_t state_nxt;
	tglg_pkg::tglg_kind_t  kind_nxt;
	tglg_pkg::tglg_item_t  item_s1;
	logic                  valid_s1;
	tglg_pkg::tglg_state_t result_s2;
	tglg_pkg::tglg_kind_t  kind_s2;
	logic                  valid_s2;
	logic                  advance;

	// The input register moves on whenever the result register is empty or being drained.
	assign advance   = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.critical_temp  <= 11'd900;
			cfg_q.throttle_temp  <= 11'd850;
			cfg_q.recover_temp   <= 11'd800;
			cfg_q.power_floor    <= 14'd500;
			cfg_q.power_ceiling  <= 14'd3000;
			cfg_q.throttle_power <= 14'd1250;
			cfg_q.freq_floor     <= 12'd200;
			cfg_q.throttle_freq  <= 12'd1350;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				tglg_pkg::REG_CRITICAL_TEMP:  cfg_q.critical_temp  <= cfg_data[10:0];
				tglg_pkg::REG_THROTTLE_TEMP:  cfg_q.throttle_temp  <= cfg_data[10:0];
				tglg_pkg::REG_RECOVER_TEMP:   cfg_q.recover_temp   <= cfg_data[10:0];
				tglg_pkg::REG_POWER_FLOOR:    cfg_q.power_floor    <= cfg_data[13:0];
				tglg_pkg::REG_POWER_CEILING:  cfg_q.power_ceiling  <= cfg_data[13:0];
				tglg_pkg::REG_THROTTLE_POWER: cfg_q.throttle_power <= cfg_data[13:0];
				tglg_pkg::REG_FREQ_FLOOR:     cfg_q.freq_floor     <= cfg_data[11:0];
				tglg_pkg::REG_THROTTLE_FREQ:  cfg_q.throttle_freq  <= cfg_data[11:0];
				default: begin
				end
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.cmd           <= tglg_pkg::tglg_cmd_t'(s_tuser);
			item_s1.temperature   <= s_tdata[11:0];
			item_s1.power_request <= s_tdata[25:12];
			item_s1.freq_request  <= s_tdata[37:26];
			item_s1.now_ms        <= s_tdata[69:38];
		end
	end

	tglg_step #(
		.FREQ_CEILING(FREQ_CEILING)
	) u_step (
		.cfg  (cfg_q),
		.state(state_q),
		.item (item_s1),
		.nxt  (state_nxt),
		.kind (kind_nxt)
	);

	// Governor state commits together with the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.power_limit   <= tglg_pkg::POWER_LIMIT_RESET;
			state_q.freq_limit    <= FreqCeil;
			state_q.guard         <= 1'b0;
			state_q.event_total   <= '0;
			state_q.last_event_ms <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= state_nxt;
			kind_s2   <= kind_nxt;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {5'b0, result_s2.last_event_ms, result_s2.event_total,
		result_s2.guard, result_s2.freq_limit, result_s2.power_limit};
	assign m_tuser  = kind_s2;

	// Counted events never make the total go down.
	`TGLG_ASSERT_NEXT(a_total_monotonic, 1'b1, state_q.event_total >= $past(state_q.event_total), "event total decreased")
	// Only a sample or a reset command may release the guard.
	`TGLG_ASSERT_SAME(a_guard_release, advance && state_q.guard && !state_nxt.guard, item_s1.cmd == tglg_pkg::CMD_SAMPLE || item_s1.cmd == tglg_pkg::CMD_RESET, "guard released by wrong command")
	// A critical or engage event records the item time.
	`TGLG_ASSERT_SAME(a_event_time, advance && (kind_nxt == tglg_pkg::KIND_CRITICAL || kind_nxt == tglg_pkg::KIND_ENGAGED), state_nxt.last_event_ms == item_s1.now_ms, "event time not recorded")
	// A held input item must not be overwritten.
	`TGLG_ASSERT_SAME(a_input_hold, valid_s1 && !advance, !s_tready, "input register overwritten while stalled")

endmodule

[sim/thermal_guard_limit_governor_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thermal guard limit governor core testbench
// Drives samples, requests, emergency stops and resets on the input stream
// under many threshold settings. A predictor of the governor computes the
// result of each accepted item, and every result item is checked field by
// field against it in order, with random idling on both streams.
// ----------------------------------------------------------------------------
module thermal_guard_limit_governor_core_tb;
	import tglg_pkg::*;

	localparam int unsigned FREQ_CEILING = 2500;
	localparam int RESET_CYCLES = 6;
	// Extra wait after the results drain, so that a late or spurious item
	// still shows up before moving on.
	localparam int SETTLE_CYCLES = 6;
	localparam int DRAIN_LIMIT = 20000;
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int RANDOM_ITEMS = 1900;
	localparam int RANDOM_PHASES = 10;
	// Keeps the log readable if the block goes badly wrong.
	localparam int REPORT_LIMIT = 100;

	localparam logic [2:0] CMD_UNUSED_LOW = 3'd5;
	localparam logic [2:0] CMD_UNUSED_MID = 3'd6;
	localparam logic [2:0] CMD_UNUSED_HIGH = 3'd7;
	localparam logic [7:0] REG_UNMAPPED_FIRST = 8'd8;
	localparam logic [7:0] REG_INDEX_LAST = 8'hFF;
	localparam logic [15:0] EVENT_TOTAL_MAX = 16'hFFFF;

	typedef struct {
		tglg_state_t limits;
		tglg_kind_t  kind;
	} governor_result_t;

	typedef enum logic [1:0] {
		READY_ALWAYS,
		READY_HALF,
		READY_ONE_IN_FOUR,
		READY_MOSTLY
	} ready_pattern_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [71:0] s_tdata = '0;
	logic [2:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [79:0] m_tdata;
	logic [2:0]  m_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	// Predicted thresholds and governor state, both updated at the edge where
	// the block takes the write or the item.
	tglg_cfg_t   gov_cfg;
	tglg_state_t gov_state;
	governor_result_t expected_results[$];

	int          failures = 0;
	int unsigned cycle_count = 0;
	int          burst_left = 0;
	ready_pattern_t ready_pattern = READY_ALWAYS;
	int          pattern_left = 0;

	thermal_guard_limit_governor_core #(
		.FREQ_CEILING(FREQ_CEILING)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #6 clk = ~clk;

	// The run is bounded so that a hung handshake cannot stall it forever.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// The receiver switches between a few stall patterns every so often,
	// including stretches where it never stalls at all.
	always @(posedge clk) begin
		if (pattern_left == 0) begin
			ready_pattern <= ready_pattern_t'($urandom_range(0, 3));
			pattern_left <= $urandom_range(16, 200);
		end else begin
			pattern_left <= pattern_left - 1;
		end
		case (ready_pattern)
			READY_ALWAYS: begin
				m_tready <= 1'b1;
			end
			READY_HALF: begin
				m_tready <= 1'($urandom_range(0, 1));
			end
			READY_ONE_IN_FOUR: begin
				m_tready <= (cycle_count[1:0] == 2'd0);
			end
			default: begin
				m_tready <= ($urandom_range(0, 7) != 0);
			end
		endcase
	end

	// Clamp with the floor checked first: with a floor above the ceiling, a value below the floor gives the floor.
	function automatic logic [13:0] bound_value(input logic [13:0] v, input logic [13:0] lo,
		input logic [13:0] hi);
		if (v < lo) begin
			return lo;
		end
		if (v > hi) begin
			return hi;
		end
		return v;
	endfunction

	// The counter stops at its maximum, but the event time is still taken.
	function automatic void note_event(input logic [31:0] now_ms);
		if (gov_state.event_total != EVENT_TOTAL_MAX) begin
			gov_state.event_total = gov_state.event_total + 16'd1;
		end
		gov_state.last_event_ms = now_ms;
	endfunction

	function automatic void reset_governor_model();
		gov_cfg.critical_temp = 11'd900;
		gov_cfg.throttle_temp = 11'd850;
		gov_cfg.recover_temp = 11'd800;
		gov_cfg.power_floor = 14'd500;
		gov_cfg.power_ceiling = 14'd3000;
		gov_cfg.throttle_power = 14'd1250;
		gov_cfg.freq_floor = 12'd200;
		gov_cfg.throttle_freq = 12'd1350;
		gov_state.power_limit = POWER_LIMIT_RESET;
		gov_state.freq_limit = 12'(FREQ_CEILING);
		gov_state.guard = 1'b0;
		gov_state.event_total = '0;
		gov_state.last_event_ms = '0;
	endfunction

	// Advances the predicted governor by one item and returns the result the
	// block has to produce for it.
	function automatic governor_result_t step_governor(input tglg_item_t it);
		governor_result_t res;
		int temp;
		logic [13:0] r;
		logic [13:0] fceil;
		temp = $signed(it.temperature);
		fceil = 14'(FREQ_CEILING);
		res.kind = KIND_NONE;
		case (it.cmd)
			CMD_SAMPLE: begin
				if (temp >= int'(gov_cfg.critical_temp)) begin
					// A critical sample skips the recovery check entirely.
					gov_state.power_limit = gov_cfg.power_floor;
					gov_state.freq_limit = gov_cfg.freq_floor;
					gov_state.guard = 1'b1;
					note_event(it.now_ms);
					res.kind = KIND_CRITICAL;
				end else begin
					if (temp >= int'(gov_cfg.throttle_temp)) begin
						if (!gov_state.guard) begin
							gov_state.guard = 1'b1;
							note_event(it.now_ms);
							res.kind = KIND_ENGAGED;
						end
						gov_state.power_limit = bound_value(gov_cfg.throttle_power,
							gov_cfg.power_floor, gov_cfg.power_ceiling);
					end
					// With recovery set above throttle, one sample can engage and
					// release the guard at once.
					if (gov_state.guard && temp < int'(gov_cfg.recover_temp)) begin
						gov_state.guard = 1'b0;
						res.kind = KIND_RECOVERED;
					end
				end
			end
			CMD_POWER_REQ: begin
				r = bound_value(it.power_request, gov_cfg.power_floor, gov_cfg.power_ceiling);
				if (r != it.power_request) begin
					res.kind = KIND_CLAMPED;
				end
				if (gov_state.guard && r > gov_cfg.throttle_power) begin
					r = gov_cfg.throttle_power;
					res.kind = KIND_CAPPED;
				end
				gov_state.power_limit = r;
			end
			CMD_FREQ_REQ: begin
				r = bound_value({2'b00, it.freq_request}, {2'b00, gov_cfg.freq_floor}, fceil);
				if (r != {2'b00, it.freq_request}) begin
					res.kind = KIND_CLAMPED;
				end
				if (gov_state.guard && r > {2'b00, gov_cfg.throttle_freq}) begin
					r = {2'b00, gov_cfg.throttle_freq};
					res.kind = KIND_CAPPED;
				end
				gov_state.freq_limit = r[11:0];
			end
			CMD_ESTOP: begin
				gov_state.power_limit = gov_cfg.power_floor;
				gov_state.freq_limit = gov_cfg.freq_floor;
				gov_state.guard = 1'b1;
			end
			CMD_RESET: begin
				gov_state.power_limit = gov_cfg.power_ceiling;
				gov_state.freq_limit = fceil[11:0];
				gov_state.guard = 1'b0;
			end
			default: begin
				// Unused command codes leave everything as it is.
			end
		endcase
		res.limits = gov_state;
		return res;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			failures++;
			if (failures <= REPORT_LIMIT) begin
				$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			end
		end
	endfunction

	// Every result item taken by the receiver is held against the oldest
	// prediction still waiting.
	always @(posedge clk) begin : check_results
		governor_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_results.size() == 0) begin
				failures++;
				if (failures <= REPORT_LIMIT) begin
					$error("result item arrived with no item expected");
				end
			end else begin
				want = expected_results.pop_front();
				check_field("power_limit", 32'(want.limits.power_limit), 32'(m_tdata[13:0]));
				check_field("freq_limit", 32'(want.limits.freq_limit), 32'(m_tdata[25:14]));
				check_field("guard_active", 32'(want.limits.guard), 32'(m_tdata[26]));
				check_field("event_total", 32'(want.limits.event_total), 32'(m_tdata[42:27]));
				check_field("last_event_ms", want.limits.last_event_ms, m_tdata[74:43]);
				check_field("event_kind", 32'(want.kind), 32'(m_tuser));
			end
		end
	end

	// The sender works in bursts; between bursts it drops tvalid for a while.
	// Now and then a long burst runs with no idling at all.
	task automatic pace_sender();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = $urandom_range(1, 8);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
			if ($urandom_range(0, 7) == 0) begin
				burst_left = $urandom_range(100, 300);
			end else begin
				burst_left = $urandom_range(1, 24);
			end
		end
	endtask

	// Presents one item, waits until the block takes it and records what it
	// has to produce. tvalid stays high so the next item can follow directly.
	task automatic send_item(input tglg_item_t it);
		s_tvalid <= 1'b1;
		s_tuser <= it.cmd;
		s_tdata <= {2'b00, it.now_ms, it.freq_request, it.power_request, it.temperature};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		expected_results.push_back(step_governor(it));
		pace_sender();
	endtask

	task automatic wait_results_drained();
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [7:0] index, input logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (index)
			REG_CRITICAL_TEMP: gov_cfg.critical_temp = value[10:0];
			REG_THROTTLE_TEMP: gov_cfg.throttle_temp = value[10:0];
			REG_RECOVER_TEMP: gov_cfg.recover_temp = value[10:0];
			REG_POWER_FLOOR: gov_cfg.power_floor = value[13:0];
			REG_POWER_CEILING: gov_cfg.power_ceiling = value[13:0];
			REG_THROTTLE_POWER: gov_cfg.throttle_power = value[13:0];
			REG_FREQ_FLOOR: gov_cfg.freq_floor = value[11:0];
			REG_THROTTLE_FREQ: gov_cfg.throttle_freq = value[11:0];
			default: begin
				// Writes to unmapped indexes are dropped.
			end
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Random junk above a register's width must be ignored by the block.
	function automatic logic [15:0] with_noise(input logic [15:0] field, input logic [15:0] mask);
		logic [15:0] junk;
		junk = $urandom_range(0, 1) ? (16'($urandom) & ~mask) : 16'h0000;
		return junk | (field & mask);
	endfunction

	function automatic tglg_cfg_t settings(input int crit, input int thr, input int rec,
		input int pfloor, input int pceil, input int tpower, input int ffloor, input int tfreq);
		tglg_cfg_t s;
		s.critical_temp = 11'(crit);
		s.throttle_temp = 11'(thr);
		s.recover_temp = 11'(rec);
		s.power_floor = 14'(pfloor);
		s.power_ceiling = 14'(pceil);
		s.throttle_power = 14'(tpower);
		s.freq_floor = 12'(ffloor);
		s.throttle_freq = 12'(tfreq);
		return s;
	endfunction

	// Settings are only changed once every result in flight has come back.
	task automatic apply_settings(input tglg_cfg_t s);
		wait_results_drained();
		write_reg(REG_CRITICAL_TEMP, with_noise(16'(s.critical_temp), 16'h07FF));
		write_reg(REG_THROTTLE_TEMP, with_noise(16'(s.throttle_temp), 16'h07FF));
		write_reg(REG_RECOVER_TEMP, with_noise(16'(s.recover_temp), 16'h07FF));
		write_reg(REG_POWER_FLOOR, with_noise(16'(s.power_floor), 16'h3FFF));
		write_reg(REG_POWER_CEILING, with_noise(16'(s.power_ceiling), 16'h3FFF));
		write_reg(REG_THROTTLE_POWER, with_noise(16'(s.throttle_power), 16'h3FFF));
		write_reg(REG_FREQ_FLOOR, with_noise(16'(s.freq_floor), 16'h0FFF));
		write_reg(REG_THROTTLE_FREQ, with_noise(16'(s.throttle_freq), 16'h0FFF));
		write_reg(8'($urandom_range(int'(REG_UNMAPPED_FIRST), int'(REG_INDEX_LAST))),
			16'($urandom));
	endtask

	// Builds an item with the given fields and a random timestamp.
	function automatic tglg_item_t compose(input logic [2:0] cmd, input int temp,
		input int preq, input int freq);
		tglg_item_t it;
		it.cmd = tglg_cmd_t'(cmd);
		it.temperature = 12'(temp);
		it.power_request = 14'(preq);
		it.freq_request = 12'(freq);
		it.now_ms = $urandom;
		return it;
	endfunction

	function automatic int near(input int base);
		return base + $urandom_range(0, 6) - 3;
	endfunction

	// Most samples land close to one of the thresholds so the guard keeps
	// engaging and releasing; most requests land close to a floor, ceiling or
	// cap. The rest is plain noise over the whole field.
	function automatic tglg_item_t random_item();
		tglg_item_t it;
		int pick;
		it = compose(CMD_SAMPLE, $urandom, $urandom, $urandom);
		pick = $urandom_range(0, 99);
		if (pick < 45) begin
			case ($urandom_range(0, 4))
				0: it.temperature = 12'(near(int'(gov_cfg.critical_temp)));
				1: it.temperature = 12'(near(int'(gov_cfg.throttle_temp)));
				2: it.temperature = 12'(near(int'(gov_cfg.recover_temp)));
				3: it.temperature = 12'(int'($urandom_range(0, 1900)) - 400);
				default: begin
				end
			endcase
		end else if (pick < 65) begin
			it.cmd = CMD_POWER_REQ;
			case ($urandom_range(0, 4))
				0: it.power_request = 14'(near(int'(gov_cfg.power_floor)));
				1: it.power_request = 14'(near(int'(gov_cfg.power_ceiling)));
				2: it.power_request = 14'(near(int'(gov_cfg.throttle_power)));
				3: it.power_request = 14'($urandom_range(0, 10000));
				default: begin
				end
			endcase
		end else if (pick < 85) begin
			it.cmd = CMD_FREQ_REQ;
			case ($urandom_range(0, 3))
				0: it.freq_request = 12'(near(int'(gov_cfg.freq_floor)));
				1: it.freq_request = 12'(near(FREQ_CEILING));
				2: it.freq_request = 12'(near(int'(gov_cfg.throttle_freq)));
				default: begin
				end
			endcase
		end else if (pick < 91) begin
			it.cmd = CMD_ESTOP;
		end else if (pick < 97) begin
			it.cmd = CMD_RESET;
		end else begin
			it.cmd = tglg_cmd_t'(3'($urandom_range(CMD_UNUSED_LOW, CMD_UNUSED_HIGH)));
		end
		return it;
	endfunction

	// Walks the default settings through every command: clamping at both
	// ends of each request, engaging, re-engaging, capping, recovering, the
	// critical floors, the emergency stop, the reset and the unused codes.
	task automatic test_directed_basics();
		send_item(compose(CMD_SAMPLE, -2048, 0, 0));
		send_item(compose(CMD_POWER_REQ, 0, 0, 0));
		send_item(compose(CMD_POWER_REQ, 0, 16383, 0));
		send_item(compose(CMD_POWER_REQ, 0, 2000, 0));
		send_item(compose(CMD_FREQ_REQ, 0, 0, 0));
		send_item(compose(CMD_FREQ_REQ, 0, 0, 4095));
		send_item(compose(CMD_FREQ_REQ, 0, 0, 1000));
		send_item(compose(CMD_SAMPLE, 850, 0, 0));
		send_item(compose(CMD_SAMPLE, 860, 0, 0));
		send_item(compose(CMD_POWER_REQ, 0, 3000, 0));
		send_item(compose(CMD_POWER_REQ, 0, 16383, 0));
		send_item(compose(CMD_FREQ_REQ, 0, 0, 2000));
		send_item(compose(CMD_SAMPLE, 820, 0, 0));
		send_item(compose(CMD_SAMPLE, 799, 0, 0));
		send_item(compose(CMD_SAMPLE, 900, 0, 0));
		send_item(compose(CMD_SAMPLE, 2047, 0, 0));
		send_item(compose(CMD_RESET, $urandom, $urandom, $urandom));
		send_item(compose(CMD_ESTOP, $urandom, $urandom, $urandom));
		send_item(compose(CMD_SAMPLE, 800, 0, 0));
		send_item(compose(CMD_UNUSED_LOW, $urandom, $urandom, $urandom));
		send_item(compose(CMD_UNUSED_MID, $urandom, $urandom, $urandom));
		send_item(compose(CMD_UNUSED_HIGH, $urandom, $urandom, $urandom));
		send_item(compose(CMD_RESET, $urandom, $urandom, $urandom));
	endtask

	// Settings where the usual ordering of thresholds and limits breaks.
	task automatic test_special_settings();
		// Recovery above throttle and a throttle power below the floor.
		apply_settings(settings(1200, 600, 900, 800, 5000, 100, 300, 2000));
		write_reg(REG_INDEX_LAST, 16'hFFFF);
		send_item(compose(CMD_SAMPLE, 700, 0, 0));
		send_item(compose(CMD_SAMPLE, 950, 0, 0));
		send_item(compose(CMD_POWER_REQ, 0, 5000, 0));
		// Floors above ceilings and a throttle power above the ceiling.
		apply_settings(settings(1500, 1000, 500, 6000, 2000, 9000, 3000, 100));
		send_item(compose(CMD_POWER_REQ, 0, 100, 0));
		send_item(compose(CMD_POWER_REQ, 0, 7000, 0));
		send_item(compose(CMD_FREQ_REQ, 0, 0, 2600));
		send_item(compose(CMD_SAMPLE, 1000, 0, 0));
	endtask

	task automatic test_random_settings();
		tglg_cfg_t s;
		int crit;
		int thr;
		int pfloor;
		int pceil;
		int ffloor;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				0: s = settings(900, 850, 800, 500, 3000, 1250, 200, 1350);
				1: s = settings(0, 0, 0, 0, 0, 0, 0, 0);
				2: s = settings(2047, 2047, 2047, 16383, 16383, 16383, 4095, 4095);
				3: s = settings(1100, 700, 600, 6000, 2000, 4000, 3000, 1000);
				4: s = settings(1200, 600, 900, 800, 5000, 100, 300, 2000);
				5: s = settings(950, 880, 820, 1000, 4000, 9000, 500, 3000);
				8: s = settings($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom);
				default: begin
					crit = $urandom_range(600, 1500);
					thr = $urandom_range(300, crit);
					pfloor = $urandom_range(0, 3000);
					pceil = $urandom_range(pfloor, 10000);
					ffloor = $urandom_range(0, 1000);
					s = settings(crit, thr, $urandom_range(0, thr), pfloor, pceil,
						$urandom_range(pfloor, pceil), ffloor, $urandom_range(ffloor, 4095));
				end
			endcase
			apply_settings(s);
			for (int n = 0; n < RANDOM_ITEMS / RANDOM_PHASES; n++) begin
				send_item(random_item());
				// Occasionally hold off until the block has nothing in flight.
				if ($urandom_range(0, 149) == 0) begin
					wait_results_drained();
				end
			end
		end
	endtask

	initial begin : run_tests
		int waited;
		reset_governor_model();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_basics();
		test_special_settings();
		test_random_settings();
		s_tvalid <= 1'b0;
		waited = 0;
		while (expected_results.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_results.size() != 0) begin
			$error("%0d expected result items never arrived", expected_results.size());
		end
		if (failures == 0 && expected_results.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
